[hw/rtl/kpc_pkg.sv]
// shared types and constants of the key press classifier
package kpc_pkg;

    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_W   = 4;
    localparam int HOLD_W  = 8;
    localparam int EVENT_W = 4;

    localparam logic [KEY_W-1:0] KEY_NONE  = 4'h0;
    localparam logic [KEY_W-1:0] KEY_POWER = 4'h1;
    localparam logic [KEY_W-1:0] KEY_SOS   = 4'h2;
    localparam logic [KEY_W-1:0] KEY_CALL1 = 4'h4;
    localparam logic [KEY_W-1:0] KEY_CALL2 = 4'h8;

    localparam logic [EVENT_W-1:0] EV_NONE        = 4'd0;
    localparam logic [EVENT_W-1:0] EV_POWER_SHORT = 4'd1;
    localparam logic [EVENT_W-1:0] EV_SOS_SHORT   = 4'd2;
    localparam logic [EVENT_W-1:0] EV_SOS_LONG    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_CALL1_SHORT = 4'd4;
    localparam logic [EVENT_W-1:0] EV_CALL1_LONG  = 4'd5;
    localparam logic [EVENT_W-1:0] EV_CALL2_SHORT = 4'd6;
    localparam logic [EVENT_W-1:0] EV_CALL2_LONG  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_OFF_FLASH   = 4'd8;
    localparam logic [EVENT_W-1:0] EV_OFF_GSM     = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_LONG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOS_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALL_LONG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD   = 2'd3;

    localparam logic [CFG_W-1:0] RST_POWER_LONG = 8'd80;
    localparam logic [CFG_W-1:0] RST_SOS_LONG   = 8'd60;
    localparam logic [CFG_W-1:0] RST_CALL_LONG  = 8'd40;
    localparam logic [CFG_W-1:0] RST_MAX_HOLD   = 8'd85;

    typedef struct packed {
        logic               scan_ended;
        logic               vibrate;
        logic               beep_clear;
        logic [EVENT_W-1:0] key_event;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_beat;

endpackage

[hw/rtl/kpc_front.sv]
// front end: config registers, key priority select, hold counter and event classification
module kpc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_power_pressed,
    input  logic                          i_sos_pressed,
    input  logic                          i_call1_pressed,
    input  logic                          i_call2_pressed,
    input  logic                          i_in_call,
    input  logic                          i_gsm_ready,
    input  logic                          i_event_pending,
    input  logic                          i_q_full,
    output kpc_pkg::t_beat                o_push
);

    logic [kpc_pkg::CFG_W-1:0]   r_power_long;
    logic [kpc_pkg::CFG_W-1:0]   r_sos_long;
    logic [kpc_pkg::CFG_W-1:0]   r_call_long;
    logic [kpc_pkg::CFG_W-1:0]   r_max_hold;
    logic [kpc_pkg::KEY_W-1:0]   r_last_key;
    logic [kpc_pkg::HOLD_W-1:0]  r_hold;
    logic [kpc_pkg::KEY_W-1:0]   n_last_key;
    logic [kpc_pkg::HOLD_W-1:0]  n_hold;
    logic [kpc_pkg::KEY_W-1:0]   key;
    logic [kpc_pkg::HOLD_W-1:0]  hold_inc;
    logic [kpc_pkg::EVENT_W-1:0] ev;
    logic                        accept;
    kpc_pkg::t_result            res;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign hold_inc = r_hold + kpc_pkg::HOLD_W'(1);

    always_comb begin
        if (i_power_pressed) begin
            key = kpc_pkg::KEY_POWER;
        end else if (i_sos_pressed) begin
            key = kpc_pkg::KEY_SOS;
        end else if (i_call1_pressed) begin
            key = kpc_pkg::KEY_CALL1;
        end else if (i_call2_pressed) begin
            key = kpc_pkg::KEY_CALL2;
        end else begin
            key = kpc_pkg::KEY_NONE;
        end
    end

    // event for a repeated key after the counter step
    always_comb begin
        ev = kpc_pkg::EV_NONE;
        if (i_in_call) begin
            if (hold_inc != '0) begin
                case (key)
                    kpc_pkg::KEY_POWER: ev = kpc_pkg::EV_POWER_SHORT;
                    kpc_pkg::KEY_SOS:   ev = kpc_pkg::EV_SOS_SHORT;
                    kpc_pkg::KEY_CALL1: ev = kpc_pkg::EV_CALL1_SHORT;
                    default:            ev = kpc_pkg::EV_CALL2_SHORT;
                endcase
            end
        end else begin
            case (key)
                kpc_pkg::KEY_POWER: begin
                    if (hold_inc >= r_power_long) begin
                        ev = i_gsm_ready ? kpc_pkg::EV_OFF_FLASH : kpc_pkg::EV_OFF_GSM;
                    end
                end
                kpc_pkg::KEY_SOS: begin
                    if (hold_inc >= r_sos_long) ev = kpc_pkg::EV_SOS_LONG;
                end
                kpc_pkg::KEY_CALL1: begin
                    if (hold_inc >= r_call_long) ev = kpc_pkg::EV_CALL1_LONG;
                end
                default: begin
                    if (hold_inc >= r_call_long) ev = kpc_pkg::EV_CALL2_LONG;
                end
            endcase
        end
    end

    always_comb begin
        n_last_key = r_last_key;
        n_hold     = r_hold;
        res        = '0;
        if (key == kpc_pkg::KEY_NONE) begin
            n_last_key     = kpc_pkg::KEY_NONE;
            n_hold         = '0;
            res.scan_ended = 1'b1;
        end else if (key != r_last_key) begin
            n_last_key = key;
            n_hold     = '0;
        end else if (i_event_pending) begin
            n_last_key     = kpc_pkg::KEY_NONE;
            n_hold         = '0;
            res.scan_ended = 1'b1;
        end else begin
            n_hold         = hold_inc;
            res.beep_clear = (hold_inc == kpc_pkg::HOLD_W'(1));
            res.key_event  = ev;
            if (ev != kpc_pkg::EV_NONE || hold_inc > r_max_hold) begin
                n_last_key     = kpc_pkg::KEY_NONE;
                n_hold         = '0;
                res.vibrate    = 1'b1;
                res.scan_ended = 1'b1;
            end
        end
    end

    assign o_push.valid = accept;
    assign o_push.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_long <= kpc_pkg::RST_POWER_LONG;
            r_sos_long   <= kpc_pkg::RST_SOS_LONG;
            r_call_long  <= kpc_pkg::RST_CALL_LONG;
            r_max_hold   <= kpc_pkg::RST_MAX_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kpc_pkg::REG_POWER_LONG: r_power_long <= i_cfg_wdata;
                kpc_pkg::REG_SOS_LONG:   r_sos_long   <= i_cfg_wdata;
                kpc_pkg::REG_CALL_LONG:  r_call_long  <= i_cfg_wdata;
                kpc_pkg::REG_MAX_HOLD:   r_max_hold   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_key <= kpc_pkg::KEY_NONE;
            r_hold     <= '0;
        end else if (accept) begin
            r_last_key <= n_last_key;
            r_hold     <= n_hold;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res.scan_ended) |=> (r_last_key == kpc_pkg::KEY_NONE && r_hold == '0))
        else $error("scan end did not clear state");

    a_vib_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (res.vibrate || res.key_event != kpc_pkg::EV_NONE)) |-> res.scan_ended)
        else $error("event or vibrate without scan end");

    a_beep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res.beep_clear && !res.scan_ended) |=> (r_hold == kpc_pkg::HOLD_W'(1)))
        else $error("beep clear without count of one");

endmodule

[hw/rtl/kpc_queue.sv]
// short result queue between front and back end
module kpc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kpc_pkg::t_beat i_push,
    input  logic           i_pop,
    output kpc_pkg::t_beat o_head,
    output logic           o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kpc_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;
    logic             empty;

    assign empty  = (r_count == '0);
    assign o_full = (r_count == CW'(DEPTH));
    assign push   = i_push.valid && !o_full;
    assign pop    = i_pop && !empty;

    assign o_head.valid = !empty;
    assign o_head.res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count over depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue lost a push");

endmodule

[hw/rtl/kpc_back.sv]
// back end: output register that drives the result stream
module kpc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kpc_pkg::t_beat   i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output kpc_pkg::t_result o_res
);

    logic             r_valid;
    kpc_pkg::t_result r_res;

    assign o_pop   = i_head.valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_head.res;
    end

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && r_res == $past(r_res)))
        else $error("output beat changed under stall");

endmodule

[hw/rtl/key_press_classifier_unit.sv]
// top level of the key press classifier
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: scan tick levels and flags
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: event, beep, vibrate; tlast
//  cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_wdata
//
// one tick per cycle while the queue is not full; each result is registered
// first by the front classify into the queue, then by the output register
// the front stalls only when the queue is full; the queue absorbs output stalls
// synchronous active-low reset clears key state, queue and output valid and
// loads the register defaults
module key_press_classifier_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // power_pressed, sos_pressed, call1_pressed, call2_pressed, in_call,
    // gsm_ready, event_pending, zero pad
    input  logic [7:0]                    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // key_event[3:0], beep_clear, vibrate, zero pad[7:6]
    output logic [7:0]                    m_axis_tdata,
    // scan_ended
    output logic                          m_axis_tlast
);

    kpc_pkg::t_beat   push;
    kpc_pkg::t_beat   head;
    kpc_pkg::t_result out_res;
    logic             q_full;
    logic             pop;

    kpc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_power_pressed (s_axis_tdata[0]),
        .i_sos_pressed   (s_axis_tdata[1]),
        .i_call1_pressed (s_axis_tdata[2]),
        .i_call2_pressed (s_axis_tdata[3]),
        .i_in_call       (s_axis_tdata[4]),
        .i_gsm_ready     (s_axis_tdata[5]),
        .i_event_pending (s_axis_tdata[6]),
        .i_q_full        (q_full),
        .o_push          (push)
    );

    kpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    kpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.vibrate, out_res.beep_clear, out_res.key_event};
    assign m_axis_tlast = out_res.scan_ended;

endmodule
